// ===== rtl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and constants for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned DeltaW   = 28;
  localparam int unsigned ChannelW = 4;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned OutFieldW = DeltaW + ChannelW + NoteW + VelW;
  localparam int unsigned OutDataW = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned LenW     = 32;
  localparam int unsigned TagCntW  = 3;

  localparam logic [7:0] TrackTag [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [7:0] StatusSysex    = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [3:0] NibNoteOff     = 4'h8;
  localparam logic [3:0] NibNoteOn      = 4'h9;
  localparam logic [3:0] NibProgram     = 4'hC;
  localparam logic [3:0] NibPressure    = 4'hD;

  typedef enum logic [KindW-1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_END      = 2'd2
  } kind_e;

  typedef enum logic [9:0] {
    PH_SEARCH   = 10'b00_0000_0001,
    PH_LENGTH   = 10'b00_0000_0010,
    PH_DELTA    = 10'b00_0000_0100,
    PH_STATUS   = 10'b00_0000_1000,
    PH_METATYPE = 10'b00_0001_0000,
    PH_SKIPLEN  = 10'b00_0010_0000,
    PH_SKIP     = 10'b00_0100_0000,
    PH_NOTE1    = 10'b00_1000_0000,
    PH_NOTE2    = 10'b01_0000_0000,
    PH_PENDEND  = 10'b10_0000_0000
  } phase_e;

endpackage

// ===== rtl/midi_track_event_parser_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Hunts for a track tag, reads the track length and parses events one byte
// per transaction, emitting note-on, note-off and end-of-track results.
// ----------------------------------------------------------------------------
// Each result is registered: it is valid in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the single output register is refilled in
// the same cycle that its result is taken, so only a stalled output holds input.
// Reset: all parser state and the output valid flag clear at once; the parser
// then searches for the track tag.
module midi_track_event_parser_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: data_byte[7:0]
  input  logic [mtep_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: delta_ticks[27:0], channel[31:28], note_number[38:32],
  // velocity[45:39], zero fill[47:46]
  output logic [mtep_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: result_kind[1:0]
  output logic [mtep_pkg::KindW-1:0]     m_axis_tuser
);
  import mtep_pkg::*;

  phase_e               phase_q, phase_d;
  logic [TagCntW-1:0]   tag_cnt_q, tag_cnt_d;
  logic [LenW-1:0]      track_len_q, track_len_d;
  logic [LenW-1:0]      consumed_q, consumed_d;
  logic [DeltaW-1:0]    vlq_q, vlq_d;
  logic [DeltaW-1:0]    held_delta_q, held_delta_d;
  logic                 held_kind_q, held_kind_d;
  logic [ChannelW-1:0]  held_chan_q, held_chan_d;
  logic [NoteW-1:0]     held_note_q, held_note_d;
  logic [DeltaW-1:0]    skip_q, skip_d;

  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [OutDataW-1:0]  out_data_q;

  logic                 accept;
  logic [7:0]           byte_in;
  logic [TagCntW-1:0]   srch_cnt_in;
  logic [TagCntW-1:0]   srch_cnt;
  logic                 srch_done;
  logic [LenW-1:0]      len_shift;
  logic [DeltaW-1:0]    vlq_next;
  logic [DeltaW-1:0]    skip_dec;
  logic [LenW-1:0]      consumed_inc;
  logic                 count_byte;
  logic                 note_out;
  logic                 res_valid;
  kind_e                res_kind;
  logic [OutDataW-1:0]  res_data;
  logic [3:0]           status_hi;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_in       = s_axis_tdata;
  assign status_hi     = byte_in[7:4];
  assign len_shift     = {track_len_q[LenW-9:0], byte_in};
  assign vlq_next      = {vlq_q[DeltaW-8:0], byte_in[6:0]};
  assign skip_dec      = (skip_q != '0) ? skip_q - DeltaW'(1) : skip_q;
  assign consumed_inc  = consumed_q + LenW'(1);

  assign srch_cnt_in = (phase_q == PH_PENDEND) ? '0 : tag_cnt_q;

  always_comb begin
    srch_done = 1'b0;
    if (byte_in == TrackTag[srch_cnt_in[1:0]]) begin
      srch_cnt = srch_cnt_in + TagCntW'(1);
      if (srch_cnt_in == TagCntW'(3)) begin
        srch_cnt  = '0;
        srch_done = 1'b1;
      end
    end else begin
      srch_cnt = (byte_in == TrackTag[0]) ? TagCntW'(1) : '0;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    tag_cnt_d    = tag_cnt_q;
    track_len_d  = track_len_q;
    consumed_d   = consumed_q;
    vlq_d        = vlq_q;
    held_delta_d = held_delta_q;
    held_kind_d  = held_kind_q;
    held_chan_d  = held_chan_q;
    held_note_d  = held_note_q;
    skip_d       = skip_q;
    count_byte   = 1'b0;
    note_out     = 1'b0;
    res_valid    = 1'b0;
    res_kind     = KIND_END;
    res_data     = '0;

    unique case (phase_q)
      PH_PENDEND, PH_SEARCH: begin
        res_valid = (phase_q == PH_PENDEND);
        phase_d   = PH_SEARCH;
        tag_cnt_d = srch_cnt;
        if (srch_done) begin
          track_len_d = '0;
          phase_d     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        track_len_d = len_shift;
        tag_cnt_d   = tag_cnt_q + TagCntW'(1);
        if (tag_cnt_q == TagCntW'(3)) begin
          tag_cnt_d  = '0;
          consumed_d = '0;
          vlq_d      = '0;
          if (len_shift == '0) begin
            phase_d   = PH_SEARCH;
            res_valid = 1'b1;
          end else begin
            phase_d = PH_DELTA;
          end
        end
      end
      PH_DELTA: begin
        count_byte = 1'b1;
        vlq_d      = vlq_next;
        if (!byte_in[7]) begin
          held_delta_d = vlq_next;
          vlq_d        = '0;
          phase_d      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        count_byte = 1'b1;
        if (byte_in == StatusMeta) begin
          phase_d = PH_METATYPE;
        end else if (byte_in == StatusSysex || byte_in == StatusSysexEsc) begin
          vlq_d   = '0;
          phase_d = PH_SKIPLEN;
        end else if (status_hi == NibNoteOff || status_hi == NibNoteOn) begin
          held_kind_d = (status_hi == NibNoteOn);
          held_chan_d = byte_in[3:0];
          phase_d     = PH_NOTE1;
        end else if (status_hi == NibProgram || status_hi == NibPressure) begin
          skip_d  = DeltaW'(1);
          phase_d = PH_SKIP;
        end else begin
          skip_d  = DeltaW'(2);
          phase_d = PH_SKIP;
        end
      end
      PH_METATYPE: begin
        count_byte = 1'b1;
        vlq_d      = '0;
        phase_d    = PH_SKIPLEN;
      end
      PH_SKIPLEN: begin
        count_byte = 1'b1;
        vlq_d      = vlq_next;
        if (!byte_in[7]) begin
          skip_d  = vlq_next;
          vlq_d   = '0;
          phase_d = (vlq_next == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        count_byte = 1'b1;
        skip_d     = skip_dec;
        if (skip_dec == '0) begin
          vlq_d   = '0;
          phase_d = PH_DELTA;
        end
      end
      PH_NOTE1: begin
        count_byte  = 1'b1;
        held_note_d = byte_in[6:0];
        phase_d     = PH_NOTE2;
      end
      PH_NOTE2: begin
        count_byte = 1'b1;
        note_out   = 1'b1;
        res_valid  = 1'b1;
        res_kind   = held_kind_q ? KIND_NOTE_ON : KIND_NOTE_OFF;
        res_data   = OutDataW'({byte_in[6:0], held_note_q, held_chan_q, held_delta_q});
        vlq_d      = '0;
        phase_d    = PH_DELTA;
      end
      default: begin
        phase_d   = PH_SEARCH;
        tag_cnt_d = '0;
      end
    endcase

    if (count_byte) begin
      consumed_d = consumed_inc;
      if (consumed_inc >= track_len_q) begin
        tag_cnt_d = '0;
        if (note_out) begin
          phase_d = PH_PENDEND;
        end else begin
          phase_d   = PH_SEARCH;
          res_valid = 1'b1;
          res_kind  = KIND_END;
          res_data  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEARCH;
      tag_cnt_q    <= '0;
      track_len_q  <= '0;
      consumed_q   <= '0;
      vlq_q        <= '0;
      held_delta_q <= '0;
      held_kind_q  <= 1'b0;
      held_chan_q  <= '0;
      held_note_q  <= '0;
      skip_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        tag_cnt_q    <= tag_cnt_d;
        track_len_q  <= track_len_d;
        consumed_q   <= consumed_d;
        vlq_q        <= vlq_d;
        held_delta_q <= held_delta_d;
        held_kind_q  <= held_kind_d;
        held_chan_q  <= held_chan_d;
        held_note_q  <= held_note_d;
        skip_q       <= skip_d;
      end
      if (accept && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

`ifndef SYNTHESIS
  a_end_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> (m_axis_tdata == '0))
    else $error("end-of-track transaction carries a nonzero payload");

  a_pendend_after_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_d == PH_PENDEND && phase_q != PH_PENDEND)
      |=> (m_axis_tvalid && m_axis_tuser != KIND_END))
    else $error("pending track end without a note transaction in the output register");

  a_inside_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DELTA || phase_q == PH_STATUS || phase_q == PH_METATYPE ||
     phase_q == PH_SKIPLEN || phase_q == PH_SKIP || phase_q == PH_NOTE1 ||
     phase_q == PH_NOTE2) |-> (consumed_q < track_len_q))
    else $error("event parsing continued past the track length");
`endif

endmodule
